[rtl/core/rers_pkg.sv]
// ----------------------------------------------------------------------------
// Recent entry ring store package
// Shared field widths, operation codes and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rers_pkg;

   // Default ring depth.
   localparam int unsigned ENTRIES_DEF = 16;

   // Request and response field widths.
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned ID_W      = 32;
   localparam int unsigned PAYLOAD_W = 32;
   localparam int unsigned POS_W     = 4;
   localparam int unsigned LIVE_W    = 5;
   localparam int unsigned ADDS_W    = 32;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DISMISS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FETCH   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;     // request accepted this cycle
      logic walk;      // issue one slot read of the walk
      logic load_rsp;  // load the response register
   } rers_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_last;   // walk counter sits on the final slot
      logic rd_pending;  // a slot read is being evaluated this cycle
   } rers_sts_type;

endpackage

[rtl/core/rers_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one ring store request.
// ----------------------------------------------------------------------------
interface rers_req_if;
   import rers_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [MODE_W-1:0]           mode;
   logic signed [ID_W-1:0]      entry_id;
   logic [PAYLOAD_W-1:0]        entry_payload;
   logic [POS_W-1:0]            position;

   modport source (
      output valid, mode, entry_id, entry_payload, position,
      input  ready
   );

   modport sink (
      input  valid, mode, entry_id, entry_payload, position,
      output ready
   );
endinterface

[rtl/core/rers_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one ring store response.
// ----------------------------------------------------------------------------
interface rers_rsp_if;
   import rers_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        found;
   logic signed [ID_W-1:0]      found_id;
   logic [PAYLOAD_W-1:0]        found_payload;
   logic [LIVE_W-1:0]           live_count;
   logic [ADDS_W-1:0]           adds_total;

   modport source (
      output valid, found, found_id, found_payload, live_count, adds_total,
      input  ready
   );

   modport sink (
      input  valid, found, found_id, found_payload, live_count, adds_total,
      output ready
   );
endinterface

[rtl/core/rers_datapath.sv]
// ----------------------------------------------------------------------------
// Ring store datapath
// Entry memory, live marks, write pointer, counters, the slot walk used by
// dismiss and fetch, and the response register.
// ----------------------------------------------------------------------------
module rers_datapath #(
   parameter int unsigned ENTRIES = rers_pkg::ENTRIES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [rers_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [rers_pkg::ID_W-1:0]      req_entry_id,
   input  logic [rers_pkg::PAYLOAD_W-1:0]        req_entry_payload,
   input  logic [rers_pkg::POS_W-1:0]            req_position,
   input  rers_pkg::rers_cmd_type                cmd,
   output rers_pkg::rers_sts_type                sts,
   output logic                                  rsp_found,
   output logic signed [rers_pkg::ID_W-1:0]      rsp_found_id,
   output logic [rers_pkg::PAYLOAD_W-1:0]        rsp_found_payload,
   output logic [rers_pkg::LIVE_W-1:0]           rsp_live_count,
   output logic [rers_pkg::ADDS_W-1:0]           rsp_adds_total
);
   import rers_pkg::*;

   localparam int unsigned ADDR_W  = $clog2(ENTRIES);
   localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
   localparam int unsigned EXT_W   = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
   localparam int unsigned ENTRY_W = ID_W + PAYLOAD_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

   // Entry memory: id in the upper half, payload in the lower half.
   logic [ENTRY_W-1:0]     mem [ENTRIES];
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   mem_wr_en;

   // Request fields held for the duration of a walk.
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [POS_W-1:0]       pos_ff, pos_in;

   // Ring state.
   logic [ENTRIES-1:0]     live_ff, live_in;
   logic [ADDR_W-1:0]      wr_slot_ff, wr_slot_in;
   logic [ADDS_W-1:0]      adds_ff, adds_in;
   logic [CNT_W-1:0]       live_cnt_ff, live_cnt_in;

   // Walk state.
   logic [ADDR_W-1:0]      walk_addr_ff, walk_addr_in;
   logic [ADDR_W-1:0]      walk_cnt_ff, walk_cnt_in;
   logic                   rd_valid_ff;
   logic [ADDR_W-1:0]      rd_addr_ff;
   logic [POS_W-1:0]       seen_ff, seen_in;

   // Fetch outcome.
   logic                   found_ff, found_in;
   logic [ID_W-1:0]        fid_ff, fid_in;
   logic [PAYLOAD_W-1:0]   fpay_ff, fpay_in;

   // Response register.
   logic                   rsp_found_ff;
   logic [ID_W-1:0]        rsp_id_ff;
   logic [PAYLOAD_W-1:0]   rsp_pay_ff;
   logic [LIVE_W-1:0]      rsp_live_ff;
   logic [ADDS_W-1:0]      rsp_adds_ff;

   logic [ADDR_W-1:0]      prev_slot;
   logic [ADDR_W-1:0]      walk_inc;
   logic [ADDR_W-1:0]      walk_dec;
   logic [ID_W-1:0]        rd_id;
   logic [EXT_W-1:0]       live_ext;

   assign rd_id     = rd_data_ff[ENTRY_W-1:PAYLOAD_W];
   assign mem_wr_en = cmd.start && (req_mode == MODE_ADD);
   assign prev_slot = (wr_slot_ff == '0) ? LAST_ADDR : wr_slot_ff - ADDR_W'(1);
   assign walk_inc  = (walk_addr_ff == LAST_ADDR) ? '0 : walk_addr_ff + ADDR_W'(1);
   assign walk_dec  = (walk_addr_ff == '0) ? LAST_ADDR : walk_addr_ff - ADDR_W'(1);
   assign live_ext  = EXT_W'(live_cnt_ff);

   // Next-state logic for the ring, the walk and the fetch outcome.
   always_comb begin
      mode_in     = mode_ff;
      id_in       = id_ff;
      pos_in      = pos_ff;
      live_in     = live_ff;
      wr_slot_in  = wr_slot_ff;
      adds_in     = adds_ff;
      live_cnt_in = live_cnt_ff;
      walk_addr_in = walk_addr_ff;
      walk_cnt_in = walk_cnt_ff;
      seen_in     = seen_ff;
      found_in    = found_ff;
      fid_in      = fid_ff;
      fpay_in     = fpay_ff;

      // Accept: latch the request and apply add or clear at once.
      if (cmd.start) begin
         mode_in      = req_mode;
         id_in        = req_entry_id;
         pos_in       = req_position;
         found_in     = 1'b0;
         fid_in       = '0;
         fpay_in      = '0;
         seen_in      = '0;
         walk_cnt_in  = '0;
         walk_addr_in = (req_mode == MODE_FETCH) ? prev_slot : '0;
         unique case (req_mode)
            MODE_ADD: begin
               live_in[wr_slot_ff] = 1'b1;
               if (!live_ff[wr_slot_ff]) begin
                  live_cnt_in = live_cnt_ff + CNT_W'(1);
               end
               wr_slot_in = (wr_slot_ff == LAST_ADDR) ? '0 : wr_slot_ff + ADDR_W'(1);
               adds_in    = adds_ff + ADDS_W'(1);
            end
            MODE_CLEAR: begin
               live_in     = '0;
               live_cnt_in = '0;
            end
            MODE_DISMISS: begin
            end
            MODE_FETCH: begin
            end
         endcase
      end

      // Walk: dismiss goes upward from slot zero, fetch goes from newest back.
      if (cmd.walk) begin
         walk_cnt_in  = walk_cnt_ff + ADDR_W'(1);
         walk_addr_in = (mode_ff == MODE_FETCH) ? walk_dec : walk_inc;
      end

      // Evaluate the slot read in the previous cycle.
      if (rd_valid_ff && live_ff[rd_addr_ff]) begin
         if (mode_ff == MODE_DISMISS) begin
            if (rd_id == id_ff) begin
               live_in[rd_addr_ff] = 1'b0;
               live_cnt_in         = live_cnt_ff - CNT_W'(1);
            end
         end else if (!found_ff) begin
            if (seen_ff == pos_ff) begin
               found_in = 1'b1;
               fid_in   = rd_id;
               fpay_in  = rd_data_ff[PAYLOAD_W-1:0];
            end else begin
               seen_in = seen_ff + POS_W'(1);
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         wr_slot_ff   <= '0;
         adds_ff      <= '0;
         live_cnt_ff  <= '0;
         walk_addr_ff <= '0;
         walk_cnt_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         seen_ff      <= '0;
         found_ff     <= 1'b0;
      end else begin
         live_ff      <= live_in;
         wr_slot_ff   <= wr_slot_in;
         adds_ff      <= adds_in;
         live_cnt_ff  <= live_cnt_in;
         walk_addr_ff <= walk_addr_in;
         walk_cnt_ff  <= walk_cnt_in;
         rd_valid_ff  <= cmd.walk;
         seen_ff      <= seen_in;
         found_ff     <= found_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      id_ff      <= id_in;
      pos_ff     <= pos_in;
      fid_ff     <= fid_in;
      fpay_ff    <= fpay_in;
      rd_addr_ff <= walk_addr_ff;
   end

   // Entry memory write port.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[wr_slot_ff] <= {req_entry_id, req_entry_payload};
      end
   end

   // Entry memory read port, registered.
   always_ff @(posedge clock) begin
      if (cmd.walk) begin
         rd_data_ff <= mem[walk_addr_ff];
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_found_ff <= found_ff;
         rsp_id_ff    <= fid_ff;
         rsp_pay_ff   <= fpay_ff;
         rsp_live_ff  <= live_ext[LIVE_W-1:0];
         rsp_adds_ff  <= adds_ff;
      end
   end

   assign rsp_found         = rsp_found_ff;
   assign rsp_found_id      = rsp_id_ff;
   assign rsp_found_payload = rsp_pay_ff;
   assign rsp_live_count    = rsp_live_ff;
   assign rsp_adds_total    = rsp_adds_ff;

   assign sts.walk_last  = (walk_cnt_ff == LAST_ADDR);
   assign sts.rd_pending = rd_valid_ff;

   // The live counter always equals the number of live marks.
   a_live_cnt_matches: assert property (@(posedge clock) disable iff (reset)
      live_cnt_ff == CNT_W'($countones(live_ff)))
      else $error("live counter disagrees with live marks");

   // A fetch outcome, once found, is not overwritten within the walk.
   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      (found_ff && !cmd.start) |=> found_ff)
      else $error("fetch outcome lost during walk");

   // An add never reduces the live count.
   a_add_keeps_count: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> (live_cnt_ff >= $past(live_cnt_ff)))
      else $error("add reduced the live count");

endmodule

[rtl/core/rers_ctrl.sv]
// ----------------------------------------------------------------------------
// Ring store controller
// Sequences acceptance, the slot walk for dismiss and fetch, and the load of
// the response register.
// ----------------------------------------------------------------------------
module rers_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rers_pkg::MODE_W-1:0]   req_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rers_pkg::rers_cmd_type        cmd,
   input  rers_pkg::rers_sts_type        sts
);
   import rers_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WALK  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_PUSH  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        out_valid_ff, out_valid_in;
   logic        accept;
   logic        out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   assign cmd.start    = accept;
   assign cmd.walk     = (state_ff == S_WALK);
   assign cmd.load_rsp = (state_ff == S_PUSH) && out_free;

   // State transitions.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_DISMISS || req_mode == MODE_FETCH) begin
                  state_in = S_WALK;
               end else begin
                  state_in = S_PUSH;
               end
            end
         end
         S_WALK: begin
            if (sts.walk_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Response valid: set on load, cleared when the response is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_rsp) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   // The response register is only reloaded once its content is gone.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!out_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");

   // The final slot read is always evaluated before the response is formed.
   a_push_after_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH) |-> !sts.rd_pending)
      else $error("response formed with a slot read outstanding");

   // The drain cycle follows only a walk that reached its final slot.
   a_drain_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> $past(sts.walk_last))
      else $error("walk ended early");

endmodule

[rtl/core/recent_entry_ring_store_unit.sv]
// ----------------------------------------------------------------------------
// Recent entry ring store
// Ring of ENTRIES slots with add, dismiss by id, fetch nth newest live entry
// and clear, one response per request.
// ----------------------------------------------------------------------------
// Add and clear go from acceptance to the push state; dismiss and fetch first
// walk every slot once through the single read port of the entry memory, one
// slot per cycle, then pass a drain state for the read latency. The push state
// loads the response once the previous one is taken. The next request is
// accepted in the cycle after the response is loaded, even while that
// response still waits for rsp_if.ready. No clearing pass runs after reset.
module recent_entry_ring_store_unit #(
   parameter int unsigned ENTRIES = rers_pkg::ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   rers_req_if.sink     req_if,
   rers_rsp_if.source   rsp_if
);
   import rers_pkg::*;

   rers_cmd_type  cmd;
   rers_sts_type  sts;

   // Controller.
   rers_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .req_mode  (req_if.mode),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath.
   rers_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_if.mode),
      .req_entry_id      (req_if.entry_id),
      .req_entry_payload (req_if.entry_payload),
      .req_position      (req_if.position),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_found         (rsp_if.found),
      .rsp_found_id      (rsp_if.found_id),
      .rsp_found_payload (rsp_if.found_payload),
      .rsp_live_count    (rsp_if.live_count),
      .rsp_adds_total    (rsp_if.adds_total)
   );

endmodule

[tb/tb_recent_entry_ring_store_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recent entry ring store testbench
// Drives add, dismiss, fetch and clear requests through the valid/ready
// request channel and checks every response field against a local model of
// the ring. A directed opening covers the corner cases. Random traffic then
// runs through phases with no idling, sender gaps, receiver stalls and both.
// ----------------------------------------------------------------------------
module tb_recent_entry_ring_store_unit;
   import rers_pkg::*;

   localparam int unsigned RING_DEPTH = ENTRIES_DEF;
   localparam int unsigned BLOCK_LEN  = 50;
   localparam int unsigned BLOCKS     = 33;
   localparam int unsigned REPORT_MAX = 10;
   localparam int unsigned HISTORY    = 8;

   // One request as queued for the driver, with its idling phase.
   typedef struct {
      logic [MODE_W-1:0]      mode;
      logic signed [ID_W-1:0] entry_id;
      logic [PAYLOAD_W-1:0]   entry_payload;
      logic [POS_W-1:0]       position;
      int unsigned            phase;
      bit                     hold_for_drain;
   } ring_req_type;

   // One response as the ring should produce it.
   typedef struct {
      logic                   found;
      logic signed [ID_W-1:0] found_id;
      logic [PAYLOAD_W-1:0]   found_payload;
      logic [LIVE_W-1:0]      live_count;
      logic [ADDS_W-1:0]      adds_total;
   } ring_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rers_req_if req_if ();
   rers_rsp_if rsp_if ();

   recent_entry_ring_store_unit #(
      .ENTRIES (RING_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Local copy of the ring contents.
   logic signed [ID_W-1:0] ring_id [RING_DEPTH];
   logic [PAYLOAD_W-1:0]   ring_payload [RING_DEPTH];
   bit                     ring_live [RING_DEPTH];
   int unsigned            ring_head = 0;
   logic [ADDS_W-1:0]      ring_adds = '0;

   ring_req_type   pending_req_q [$];
   ring_rsp_type   expected_rsp_q [$];
   ring_req_type   drv_item;
   ring_rsp_type   mon_expected;
   int unsigned    cur_phase = 0;

   int unsigned mode_count [4];
   int unsigned fetch_hits = 0;
   int unsigned rsp_checked = 0;
   int unsigned mismatches = 0;

   // Recently added ids, so that dismisses mostly hit something.
   logic signed [ID_W-1:0] recent_ids [HISTORY];
   int unsigned            recent_wr = 0;

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Reset held at the start of the run.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard limit on the run time.
   initial begin
      #2_000_000;
      $display("recent_entry_ring_store_unit regression: fail");
      $finish;
   end

   function automatic int unsigned sender_idle_pct(int unsigned ph);
      case (ph)
         1: return 74;
         3: return 30;
         default: return 0;
      endcase
   endfunction

   function automatic int unsigned receiver_stall_pct(int unsigned ph);
      case (ph)
         2: return 74;
         3: return 30;
         default: return 0;
      endcase
   endfunction

   // Applies one accepted request to the local ring and returns the response.
   function automatic ring_rsp_type ring_predict(ring_req_type r);
      ring_rsp_type res;
      int unsigned  seen;
      int unsigned  idx;
      int unsigned  live_n;
      bit           hit;
      res = '{default: '0};
      mode_count[r.mode]++;
      case (r.mode)
         MODE_ADD: begin
            ring_id[ring_head]      = r.entry_id;
            ring_payload[ring_head] = r.entry_payload;
            ring_live[ring_head]    = 1'b1;
            ring_head = (ring_head + 1) % RING_DEPTH;
            ring_adds = ring_adds + 1'b1;
         end
         MODE_DISMISS: begin
            for (int i = 0; i < RING_DEPTH; i++)
               if (ring_live[i] && ring_id[i] == r.entry_id)
                  ring_live[i] = 1'b0;
         end
         MODE_FETCH: begin
            // Walk backwards from the newest slot, counting live entries.
            seen = 0;
            hit  = 1'b0;
            for (int k = 1; k <= RING_DEPTH; k++) begin
               idx = (ring_head + RING_DEPTH - k) % RING_DEPTH;
               if (!hit && ring_live[idx]) begin
                  if (seen == r.position) begin
                     hit               = 1'b1;
                     res.found         = 1'b1;
                     res.found_id      = ring_id[idx];
                     res.found_payload = ring_payload[idx];
                  end else begin
                     seen++;
                  end
               end
            end
            if (hit)
               fetch_hits++;
         end
         default: begin
            for (int i = 0; i < RING_DEPTH; i++)
               ring_live[i] = 1'b0;
         end
      endcase
      live_n = 0;
      for (int i = 0; i < RING_DEPTH; i++)
         if (ring_live[i])
            live_n++;
      res.live_count = LIVE_W'(live_n);
      res.adds_total = ring_adds;
      return res;
   endfunction

   function automatic ring_req_type directed_req(logic [MODE_W-1:0] mode,
                                                 logic signed [ID_W-1:0] id,
                                                 logic [PAYLOAD_W-1:0] payload,
                                                 logic [POS_W-1:0] pos);
      ring_req_type r;
      r.mode           = mode;
      r.entry_id       = id;
      r.entry_payload  = payload;
      r.position       = pos;
      r.phase          = 0;
      r.hold_for_drain = 1'b0;
      return r;
   endfunction

   // Random request: mostly adds, dismisses of recent ids and shallow fetches.
   function automatic ring_req_type random_req(int unsigned ph);
      ring_req_type r;
      int unsigned  pick;
      pick             = $urandom_range(99);
      r.phase          = ph;
      r.hold_for_drain = 1'b0;
      r.entry_payload  = $urandom();
      r.position       = ($urandom_range(1) != 0) ? POS_W'($urandom_range(3)) :
                                                    POS_W'($urandom_range(15));
      case ($urandom_range(7))
         0: r.entry_id = 32'sh8000_0000;
         1: r.entry_id = 32'sh7FFF_FFFF;
         2: r.entry_id = '0;
         3: r.entry_id = -32'sd1;
         4, 5: r.entry_id = $urandom_range(15);
         default: r.entry_id = $urandom();
      endcase
      if (pick < 45) begin
         r.mode = MODE_ADD;
         recent_ids[recent_wr] = r.entry_id;
         recent_wr = (recent_wr + 1) % HISTORY;
      end else if (pick < 65) begin
         r.mode = MODE_DISMISS;
         if ($urandom_range(3) != 0)
            r.entry_id = recent_ids[$urandom_range(HISTORY - 1)];
      end else if (pick < 95) begin
         r.mode = MODE_FETCH;
      end else begin
         r.mode = MODE_CLEAR;
      end
      return r;
   endfunction

   // Request driver: presents queued requests and records each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_rsp_q.push_back(ring_predict(drv_item));
         if (!req_if.valid || req_if.ready) begin
            if (pending_req_q.size() != 0 &&
                !(pending_req_q[0].hold_for_drain && expected_rsp_q.size() != 0) &&
                $urandom_range(99) >= sender_idle_pct(pending_req_q[0].phase)) begin
               drv_item = pending_req_q.pop_front();
               req_if.mode          <= drv_item.mode;
               req_if.entry_id      <= drv_item.entry_id;
               req_if.entry_payload <= drv_item.entry_payload;
               req_if.position      <= drv_item.position;
               req_if.valid         <= 1'b1;
               cur_phase            <= drv_item.phase;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compares each accepted response with the oldest
   // expectation and applies random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("ERROR: response with nothing outstanding at %0t", $realtime);
            end else begin
               mon_expected = expected_rsp_q.pop_front();
               rsp_checked++;
               if (rsp_if.found !== mon_expected.found ||
                   rsp_if.found_id !== mon_expected.found_id ||
                   rsp_if.found_payload !== mon_expected.found_payload ||
                   rsp_if.live_count !== mon_expected.live_count ||
                   rsp_if.adds_total !== mon_expected.adds_total) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display({"ERROR: response %0d expected found=%0b id=%0d ",
                               "payload=%h live=%0d adds=%0d, got found=%0b id=%0d ",
                               "payload=%h live=%0d adds=%0d"},
                              rsp_checked, mon_expected.found, mon_expected.found_id,
                              mon_expected.found_payload, mon_expected.live_count,
                              mon_expected.adds_total, rsp_if.found, rsp_if.found_id,
                              rsp_if.found_payload, rsp_if.live_count,
                              rsp_if.adds_total);
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct(cur_phase));
      end
   end

   // Stimulus and end of run.
   initial begin
      ring_req_type           r;
      logic signed [ID_W-1:0] id;
      logic [PAYLOAD_W-1:0]   payload;

      req_if.valid         = 1'b0;
      req_if.mode          = MODE_ADD;
      req_if.entry_id      = '0;
      req_if.entry_payload = '0;
      req_if.position      = '0;
      rsp_if.ready         = 1'b0;
      for (int i = 0; i < RING_DEPTH; i++)
         ring_live[i] = 1'b0;
      for (int i = 0; i < HISTORY; i++)
         recent_ids[i] = '0;
      for (int i = 0; i < 4; i++)
         mode_count[i] = 0;

      // Operations on an empty ring.
      pending_req_q.push_back(directed_req(MODE_FETCH, '0, '0, '0));
      pending_req_q.push_back(directed_req(MODE_DISMISS, -32'sd1, '0, '0));
      pending_req_q.push_back(directed_req(MODE_CLEAR, '0, '0, '0));

      // Fill the ring with extreme ids and payloads and one duplicated id.
      for (int i = 0; i < RING_DEPTH; i++) begin
         case (i)
            0: id = 32'sh8000_0000;
            1: id = 32'sh7FFF_FFFF;
            2: id = '0;
            3: id = -32'sd1;
            4, 9: id = 32'sd77;
            default: id = i * 1000 + $urandom_range(999);
         endcase
         case (i)
            0: payload = '0;
            1: payload = '1;
            default: payload = $urandom();
         endcase
         pending_req_q.push_back(directed_req(MODE_ADD, id, payload, POS_W'(i)));
      end

      // Overwrite the oldest live entry, then fetch deep and shallow.
      pending_req_q.push_back(directed_req(MODE_ADD, 32'sh1234_5678, 32'hA5A5_5A5A, '0));
      pending_req_q.push_back(directed_req(MODE_FETCH, '0, '0, 4'd15));
      pending_req_q.push_back(directed_req(MODE_FETCH, '0, '0, 4'd0));
      // Dismiss both copies of a duplicated id; a deep fetch then misses.
      pending_req_q.push_back(directed_req(MODE_DISMISS, 32'sd77, '0, '0));
      pending_req_q.push_back(directed_req(MODE_FETCH, '0, '0, 4'd15));
      pending_req_q.push_back(directed_req(MODE_DISMISS, 32'sh5555_AAAA, '0, '0));
      pending_req_q.push_back(directed_req(MODE_CLEAR, '0, '0, '0));
      pending_req_q.push_back(directed_req(MODE_FETCH, '0, '0, 4'd0));

      // Random traffic in blocks that rotate through the idling phases;
      // some blocks start only once the ring has answered everything.
      for (int b = 0; b < BLOCKS; b++) begin
         for (int j = 0; j < BLOCK_LEN; j++) begin
            r = random_req(b % 4);
            if (j == 0 && (b % 5) == 0)
               r.hold_for_drain = 1'b1;
            pending_req_q.push_back(r);
         end
      end

      wait (!reset && pending_req_q.size() == 0 && !req_if.valid &&
            expected_rsp_q.size() == 0);
      repeat (RING_DEPTH + 8) @(posedge clock);

      $display("Ran %0d requests: %0d adds, %0d dismisses, %0d fetches (%0d hits), %0d clears,",
               mode_count[MODE_ADD] + mode_count[MODE_DISMISS] + mode_count[MODE_FETCH] +
               mode_count[MODE_CLEAR], mode_count[MODE_ADD], mode_count[MODE_DISMISS],
               mode_count[MODE_FETCH], fetch_hits, mode_count[MODE_CLEAR]);
      $display("under four idling phases; %0d responses checked, %0d mismatches.",
               rsp_checked, mismatches);
      if (mismatches == 0) begin
         $display("recent_entry_ring_store_unit regression: pass");
      end else begin
         $display("recent_entry_ring_store_unit regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/rers_pkg.sv
rtl/core/rers_req_if.sv
rtl/core/rers_rsp_if.sv
rtl/core/rers_datapath.sv
rtl/core/rers_ctrl.sv
rtl/core/recent_entry_ring_store_unit.sv
tb/tb_recent_entry_ring_store_unit.sv
